/* design/efc_pkg.sv */
// ----------------------------------------------------------------------------
// efc_pkg: shared types and constants for the Ethernet framer
// Request entry, configuration bundle, byte kinds, register map and the
// sequencer states of the back end.
// ----------------------------------------------------------------------------
package efc_pkg;

   // byte kinds on the result channel
   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_CRC     = 2'd2,
      KIND_IDLE    = 2'd3
   } efc_kind_type;

   // register indexes (byte address = 8 * index)
   typedef enum logic [1:0] {
      REG_DEST_MAC   = 2'd0,
      REG_SRC_MAC    = 2'd1,
      REG_ETHER_TYPE = 2'd2,
      REG_MIN_IDLE   = 2'd3
   } efc_reg_type;

   // back-end sequencer states
   typedef enum logic [2:0] {
      ST_WAIT,
      ST_HEAD,
      ST_PAY,
      ST_CRC,
      ST_IDLE,
      ST_FILL
   } efc_state_type;

   // one classified request in the queue
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       first;
   } efc_entry_type;

   // configuration seen by the back end
   typedef struct packed {
      logic [47:0] dest_mac;
      logic [47:0] src_mac;
      logic [15:0] ether_type;
      logic [5:0]  min_idle;
   } efc_cfg_type;

   localparam logic [31:0] CRC_POLY       = 32'h814141AB;
   localparam logic [7:0]  PREAMBLE_FIRST = 8'hFB;
   localparam logic [7:0]  PREAMBLE_BYTE  = 8'h55;
   localparam logic [7:0]  SFD_BYTE       = 8'hD5;
   localparam logic [7:0]  IDLE_BYTE      = 8'h07;
   localparam logic [5:0]  IDLE_LIMIT     = 6'd32;
   localparam logic [4:0]  HDR_LAST       = 5'd21;

   localparam logic [47:0] DEST_MAC_RESET   = 48'd0;
   localparam logic [47:0] SRC_MAC_RESET    = 48'd0;
   localparam logic [15:0] ETHER_TYPE_RESET = 16'hDDDD;
   localparam logic [5:0]  MIN_IDLE_RESET   = 6'd12;

endpackage

/* design/efc_csr.sv */
// ----------------------------------------------------------------------------
// efc_csr: configuration register file
// APB-style write and read of the MAC addresses, ethertype and idle count.
// ----------------------------------------------------------------------------
module efc_csr
   import efc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready,
   output efc_cfg_type cfg
);

   logic [47:0] dest_mac_ff;
   logic [47:0] src_mac_ff;
   logic [15:0] ether_type_ff;
   logic [5:0]  min_idle_ff;
   logic        wr_en;
   efc_reg_type reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_sel = efc_reg_type'(paddr[4:3]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dest_mac_ff   <= DEST_MAC_RESET;
         src_mac_ff    <= SRC_MAC_RESET;
         ether_type_ff <= ETHER_TYPE_RESET;
         min_idle_ff   <= MIN_IDLE_RESET;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_DEST_MAC:   dest_mac_ff   <= pwdata[47:0];
            REG_SRC_MAC:    src_mac_ff    <= pwdata[47:0];
            REG_ETHER_TYPE: ether_type_ff <= pwdata[15:0];
            REG_MIN_IDLE:   min_idle_ff   <= pwdata[5:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      prdata = '0;
      unique case (reg_sel)
         REG_DEST_MAC:   prdata = {16'd0, dest_mac_ff};
         REG_SRC_MAC:    prdata = {16'd0, src_mac_ff};
         REG_ETHER_TYPE: prdata = {48'd0, ether_type_ff};
         REG_MIN_IDLE:   prdata = {58'd0, min_idle_ff};
         default:        prdata = '0;
      endcase
   end

   assign cfg.dest_mac   = dest_mac_ff;
   assign cfg.src_mac    = src_mac_ff;
   assign cfg.ether_type = ether_type_ff;
   assign cfg.min_idle   = min_idle_ff;

endmodule

/* design/efc_front.sv */
// ----------------------------------------------------------------------------
// efc_front: request intake
// Accepts payload bytes and marks the first byte of each frame.
// ----------------------------------------------------------------------------
module efc_front
   import efc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_payload_byte,
   input  logic          req_payload_last,
   input  logic          q_full,
   output logic          q_push,
   output efc_entry_type q_wdata
);

   logic in_frame_ff;
   logic in_frame_in;

   assign req_ready = ~q_full;
   assign q_push    = req_valid & req_ready;

   // classify: a request outside a frame opens one
   assign q_wdata.data  = req_payload_byte;
   assign q_wdata.last  = req_payload_last;
   assign q_wdata.first = ~in_frame_ff;

   always_comb begin
      in_frame_in = in_frame_ff;
      if (q_push) begin
         in_frame_in = ~req_payload_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
      end
   end

endmodule

/* design/efc_queue.sv */
// ----------------------------------------------------------------------------
// efc_queue: request queue between front and back
// Small register FIFO; the head entry is visible without popping.
// ----------------------------------------------------------------------------
module efc_queue
   import efc_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  efc_entry_type wdata,
   output logic          full,
   input  logic          pop,
   output logic          valid,
   output efc_entry_type rdata
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   efc_entry_type       slot_ff [DEPTH];
   logic [PW-1:0]       wr_ptr_ff;
   logic [PW-1:0]       wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff;
   logic [PW-1:0]       rd_ptr_in;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic                do_push;
   logic                do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign valid   = (count_ff != '0);
   assign rdata   = slot_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

/* design/efc_back.sv */
// ----------------------------------------------------------------------------
// efc_back: frame sequencer
// Emits header, payload, CRC-32Q and idle fill, one byte per cycle unless rsp
// stalls or a payload byte is awaited, into a registered result stage.
// ----------------------------------------------------------------------------
module efc_back
   import efc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  efc_cfg_type   cfg,
   input  logic          q_valid,
   input  efc_entry_type q_rdata,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [7:0]    rsp_out_byte,
   output logic [1:0]    rsp_byte_kind,
   output logic          rsp_run_last
);

   // header byte at position idx (0..21)
   function automatic logic [7:0] hdr_byte(input logic [4:0] idx, input efc_cfg_type c);
      logic [5:0]  sh;
      logic [47:0] word;
      logic [7:0]  res;
      sh   = '0;
      word = '0;
      res  = '0;
      case (idx) inside
         5'd0:          res = PREAMBLE_FIRST;
         [5'd1:5'd6]:   res = PREAMBLE_BYTE;
         5'd7:          res = SFD_BYTE;
         [5'd8:5'd13]: begin
            sh   = {3'(5'd13 - idx), 3'b000};
            word = c.dest_mac >> sh;
            res  = word[7:0];
         end
         [5'd14:5'd19]: begin
            sh   = {3'(5'd19 - idx), 3'b000};
            word = c.src_mac >> sh;
            res  = word[7:0];
         end
         5'd20:         res = c.ether_type[15:8];
         5'd21:         res = c.ether_type[7:0];
         default:       res = '0;
      endcase
      return res;
   endfunction

   // CRC-32Q over one byte, MSB first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {b, 24'd0};
      for (int k = 0; k < 8; k++) begin
         c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
      end
      return c;
   endfunction

   efc_state_type state_ff, state_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [5:0]    idle_ff, idle_in;
   logic [1:0]    len_ff, len_in;
   logic [1:0]    len_next;
   logic [31:0]   crc_ff, crc_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   efc_kind_type  rsp_kind_ff, rsp_kind_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          adv;
   logic          emit;
   logic          pay_go;
   logic          fin;
   logic [5:0]    idles;
   logic [31:0]   crc_shift;

   assign adv      = ~rsp_valid_ff | rsp_ready;
   assign len_next = len_ff + 2'd1;
   assign idles    = (cfg.min_idle > IDLE_LIMIT) ? IDLE_LIMIT : cfg.min_idle;
   assign crc_shift = crc_ff >> {~cnt_ff[1:0], 3'b000};

   // sequencer: next state and the byte to register
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idle_in      = idle_ff;
      len_in       = len_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      q_pop        = 1'b0;
      emit         = 1'b0;
      pay_go       = 1'b0;
      fin          = 1'b0;
      if (adv) begin
         unique case (state_ff)
            ST_WAIT: begin
               if (q_valid) begin
                  if (q_rdata.first) begin
                     emit        = 1'b1;
                     rsp_byte_in = hdr_byte(5'd0, cfg);
                     rsp_kind_in = KIND_HEADER;
                     rsp_last_in = 1'b0;
                     cnt_in      = 5'd1;
                     state_in    = ST_HEAD;
                  end else begin
                     pay_go = 1'b1;
                  end
               end
            end
            ST_HEAD: begin
               emit        = 1'b1;
               rsp_byte_in = hdr_byte(cnt_ff, cfg);
               rsp_kind_in = KIND_HEADER;
               rsp_last_in = 1'b0;
               cnt_in      = cnt_ff + 5'd1;
               if (cnt_ff == HDR_LAST) begin
                  state_in = ST_PAY;
               end
            end
            ST_PAY: begin
               pay_go = q_valid;
            end
            ST_CRC: begin
               emit        = 1'b1;
               rsp_byte_in = crc_shift[7:0];
               rsp_kind_in = KIND_CRC;
               rsp_last_in = 1'b0;
               cnt_in      = cnt_ff + 5'd1;
               if (cnt_ff[1:0] == 2'd3) begin
                  if (idles != '0) begin
                     idle_in  = idles;
                     state_in = ST_IDLE;
                  end else if (len_next == '0) begin
                     fin = 1'b1;
                  end else begin
                     state_in = ST_FILL;
                  end
               end
            end
            ST_IDLE: begin
               emit        = 1'b1;
               rsp_byte_in = IDLE_BYTE;
               rsp_kind_in = KIND_IDLE;
               rsp_last_in = 1'b0;
               idle_in     = idle_ff - 6'd1;
               if (idle_ff == 6'd1) begin
                  if (len_next == '0) begin
                     fin = 1'b1;
                  end else begin
                     state_in = ST_FILL;
                  end
               end
            end
            ST_FILL: begin
               emit        = 1'b1;
               rsp_byte_in = IDLE_BYTE;
               rsp_kind_in = KIND_IDLE;
               rsp_last_in = 1'b0;
               fin         = (len_next == '0);
            end
            default: begin
               state_in = ST_WAIT;
            end
         endcase
      end

      // payload byte: pass through, fold into the CRC, release the request
      if (pay_go) begin
         emit        = 1'b1;
         q_pop       = 1'b1;
         rsp_byte_in = q_rdata.data;
         rsp_kind_in = KIND_PAYLOAD;
         rsp_last_in = ~q_rdata.last;
         crc_in      = crc_byte(crc_ff, q_rdata.data);
         if (q_rdata.last) begin
            cnt_in   = '0;
            state_in = ST_CRC;
         end else begin
            state_in = ST_WAIT;
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
         len_in       = len_next;
      end

      // frame end: trailer done, back to a clean frame state
      if (fin) begin
         rsp_last_in = 1'b1;
         crc_in      = '0;
         state_in    = ST_WAIT;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WAIT;
         cnt_ff       <= '0;
         idle_ff      <= '0;
         len_ff       <= '0;
         crc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idle_ff      <= idle_in;
         len_ff       <= len_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_byte_kind = 2'(rsp_kind_ff);
   assign rsp_run_last  = rsp_last_ff;

endmodule

/* design/ethernet_framer_crc32q_unit.sv */
// ----------------------------------------------------------------------------
// ethernet_framer_crc32q_unit: Ethernet frame generator with CRC-32Q trailer
// Wraps payload bytes in preamble, SFD, MAC addresses and ethertype, appends
// a CRC-32Q (poly 814141AB, MSB first, zero init) and 07 idle fill.
//
//   channel   direction  handshake                  payload
//   req       in         req_valid / req_ready      payload_byte, payload_last
//   rsp       out        rsp_valid / rsp_ready      out_byte, byte_kind, run_last
//   csr       in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// The sequencer emits one byte per cycle unless rsp stalls or the queue is
// empty: the first byte of a frame adds 22 header bytes, the last adds 4 CRC
// bytes plus idle count and 0..3 fill bytes (up to 39 bytes after the payload).
// The request queue (QUEUE_DEPTH entries) accepts until full while the back
// end works or rsp stalls. Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ethernet_framer_crc32q_unit
   import efc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2   // 2 or more
)
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_payload_byte,
   input  logic        req_payload_last,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_byte_kind,
   output logic        rsp_run_last,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   efc_cfg_type   cfg;
   efc_entry_type q_wdata;
   efc_entry_type q_rdata;
   logic          q_push;
   logic          q_full;
   logic          q_pop;
   logic          q_valid;

   efc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   efc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload_byte (req_payload_byte),
      .req_payload_last (req_payload_last),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_wdata          (q_wdata)
   );

   efc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .valid (q_valid),
      .rdata (q_rdata)
   );

   efc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .q_valid       (q_valid),
      .q_rdata       (q_rdata),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_byte_kind (rsp_byte_kind),
      .rsp_run_last  (rsp_run_last)
   );

endmodule

/* tb/sv/ethernet_framer_crc32q_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ethernet_framer_crc32q_unit_test: self-checking bench for the frame builder
// Streams payload bytes through the framer and checks every emitted byte
// (header, payload, CRC-32Q trailer, idle fill) against a local frame model.
// Register settings are changed only between drained phases; both sides
// stall at random, but for the last random phase.
// ----------------------------------------------------------------------------
module ethernet_framer_crc32q_unit_test;
   import efc_pkg::*;

   localparam int          WATCHDOG_LIMIT = 1000;
   localparam int          TAIL_CYCLES    = 64;
   localparam int          PHASE_ITEMS    = 150;
   localparam int          PLAN_ROWS      = 26;
   localparam logic [63:0] ALL_ONES       = 64'hFFFF_FFFF_FFFF_FFFF;

   // one emitted byte as seen on the result channel
   typedef struct packed {
      logic [7:0]   data;
      efc_kind_type kind;
      logic         run_last;
   } frame_byte_type;

   typedef enum logic [0:0] {
      OP_SEND  = 1'b0,
      OP_WRITE = 1'b1
   } plan_op_type;

   // directed row: a request or a register write
   typedef struct packed {
      plan_op_type op;
      efc_reg_type reg_index;
      logic [63:0] value;
      logic [7:0]  data;
      logic        is_last;
      logic        typed;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_payload_byte;
   logic        req_payload_last;
   logic        req_typed;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_out_byte;
   logic [1:0]  rsp_byte_kind;
   logic        rsp_run_last;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic        pready;

   // frame model state and register shadow
   logic        in_frame;
   logic [31:0] crc_state;
   logic [1:0]  len_mod4;
   logic [47:0] cfg_dest_mac;
   logic [47:0] cfg_src_mac;
   logic [15:0] cfg_ether_type;
   logic [5:0]  cfg_min_idle;

   frame_byte_type predicted_run[$];
   frame_byte_type frame_bytes_due[$];
   plan_row_type   directed_plan[PLAN_ROWS];

   int send_idle_pct;
   int recv_idle_pct;
   int mismatches;
   int requests_accepted;
   int frames_accepted;
   int bytes_checked;
   int reg_writes;
   int quiet_cycles;

   ethernet_framer_crc32q_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload_byte (req_payload_byte),
      .req_payload_last (req_payload_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_kind    (rsp_byte_kind),
      .rsp_run_last     (rsp_run_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // append one byte to the run being predicted; tracks frame length mod 4
   function automatic void push_byte(input logic [7:0] value, input efc_kind_type kind);
      frame_byte_type entry;
      entry         = '{data: value, kind: kind, run_last: 1'b0};
      predicted_run = {predicted_run, entry};
      len_mod4      = len_mod4 + 2'd1;
   endfunction

   // bytes emitted for one request, built into predicted_run
   function automatic void predict_frame_bytes(input logic [7:0] data, input logic is_last);
      logic [175:0] header;
      logic [5:0]   idles;
      int           i;
      predicted_run.delete();
      if (!in_frame) begin
         in_frame  = 1'b1;
         crc_state = '0;
         len_mod4  = '0;
         header = {PREAMBLE_FIRST, {6{PREAMBLE_BYTE}}, SFD_BYTE,
                   cfg_dest_mac, cfg_src_mac, cfg_ether_type};
         for (i = 21; i >= 0; i--) push_byte(header[8*i +: 8], KIND_HEADER);
      end
      push_byte(data, KIND_PAYLOAD);
      // CRC-32Q, MSB first, one bit per pass
      crc_state = crc_state ^ {data, 24'd0};
      for (i = 0; i < 8; i++)
         crc_state = crc_state[31] ? ((crc_state << 1) ^ CRC_POLY) : (crc_state << 1);
      if (is_last) begin
         idles = (cfg_min_idle > IDLE_LIMIT) ? IDLE_LIMIT : cfg_min_idle;
         for (i = 3; i >= 0; i--) push_byte(crc_state[8*i +: 8], KIND_CRC);
         for (i = 0; i < idles; i++) push_byte(IDLE_BYTE, KIND_IDLE);
         while (len_mod4 != 2'd0) push_byte(IDLE_BYTE, KIND_IDLE);
         in_frame  = 1'b0;
         crc_state = '0;
         len_mod4  = '0;
      end
      predicted_run[predicted_run.size() - 1].run_last = 1'b1;
   endfunction

   // random register value with a bias toward all zeros and all ones
   function automatic logic [63:0] pick_value();
      case ($urandom_range(3))
         0: return 64'd0;
         1: return ALL_ONES;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // APB write: setup cycle, then access until pready
   task automatic csr_write(input efc_reg_type index, input logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (index)
         REG_DEST_MAC:   cfg_dest_mac   = value[47:0];
         REG_SRC_MAC:    cfg_src_mac    = value[47:0];
         REG_ETHER_TYPE: cfg_ether_type = value[15:0];
         REG_MIN_IDLE:   cfg_min_idle   = value[5:0];
         default: ;
      endcase
      reg_writes++;
      @(posedge clock);
   endtask

   // hold the request side and wait until every expected byte has come out
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frame_bytes_due.size() != 0) @(posedge clock);
   endtask

   // offer one request, with random idle cycles ahead of it
   task automatic send_request(input logic [7:0] data, input logic is_last,
                               input logic typed);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_payload_byte <= data;
      req_payload_last <= is_last;
      req_typed        <= typed;
      do @(posedge clock); while (!req_ready);
   endtask

   // accepted requests feed the model; accepted results are checked in order
   always @(posedge clock) begin
      frame_byte_type want;
      frame_byte_type got;
      frame_byte_type alone;
      if (!reset && req_valid && req_ready) begin
         predict_frame_bytes(req_payload_byte, req_payload_last);
         // a typed row is a mid-frame byte: it must come straight back alone
         if (req_typed) begin
            alone = '{data: req_payload_byte, kind: KIND_PAYLOAD, run_last: 1'b1};
            frame_bytes_due = {frame_bytes_due, alone};
         end else begin
            frame_bytes_due = {frame_bytes_due, predicted_run};
         end
         requests_accepted++;
         if (req_payload_last) frames_accepted++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{data: rsp_out_byte, kind: efc_kind_type'(rsp_byte_kind),
                 run_last: rsp_run_last};
         if (frame_bytes_due.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected byte %02h kind %0d last %0b", got.data, got.kind,
                        got.run_last);
            mismatches++;
         end else begin
            want = frame_bytes_due.pop_front();
            if (got != want) begin
               if (mismatches < 10)
                  $display("byte %0d: expected %02h kind %0d last %0b, got %02h kind %0d last %0b",
                           bytes_checked, want.data, want.kind, want.run_last,
                           got.data, got.kind, got.run_last);
               mismatches++;
            end
         end
         bytes_checked++;
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int row;
      int phase;
      int phase_items;
      int frame_len;
      int k;

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_payload_byte <= 8'd0;
      req_payload_last <= 1'b0;
      req_typed        <= 1'b0;
      rsp_ready        <= 1'b0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      in_frame          = 1'b0;
      crc_state         = '0;
      len_mod4          = '0;
      cfg_dest_mac      = DEST_MAC_RESET;
      cfg_src_mac       = SRC_MAC_RESET;
      cfg_ether_type    = ETHER_TYPE_RESET;
      cfg_min_idle      = MIN_IDLE_RESET;
      send_idle_pct     = 22;
      recv_idle_pct     = 61;
      mismatches        = 0;
      requests_accepted = 0;
      frames_accepted   = 0;
      bytes_checked     = 0;
      reg_writes        = 0;

      // directed part: reset settings, then extremes of every register
      directed_plan = '{
         '{OP_SEND,  REG_DEST_MAC,   64'd0,    8'h00, 1'b1, 1'b0},  // one-byte frame
         '{OP_SEND,  REG_DEST_MAC,   64'd0,    8'hFF, 1'b0, 1'b0},
         '{OP_SEND,  REG_DEST_MAC,   64'd0,    8'h00, 1'b0, 1'b1},
         '{OP_SEND,  REG_DEST_MAC,   64'd0,    8'hFF, 1'b0, 1'b1},
         '{OP_SEND,  REG_DEST_MAC,   64'd0,    8'hA5, 1'b0, 1'b1},
         '{OP_SEND,  REG_DEST_MAC,   64'd0,    8'h5A, 1'b1, 1'b0},
         '{OP_WRITE, REG_DEST_MAC,   ALL_ONES, 8'h00, 1'b0, 1'b0},
         '{OP_WRITE, REG_SRC_MAC,    ALL_ONES, 8'h00, 1'b0, 1'b0},
         '{OP_WRITE, REG_ETHER_TYPE, ALL_ONES, 8'h00, 1'b0, 1'b0},
         '{OP_WRITE, REG_MIN_IDLE,   64'd0,    8'h00, 1'b0, 1'b0},
         '{OP_SEND,  REG_DEST_MAC,   64'd0,    8'hFF, 1'b1, 1'b0},  // fill of one
         '{OP_SEND,  REG_DEST_MAC,   64'd0,    8'h80, 1'b0, 1'b0},
         '{OP_SEND,  REG_DEST_MAC,   64'd0,    8'h01, 1'b1, 1'b0},  // no fill
         '{OP_WRITE, REG_MIN_IDLE,   64'd32,   8'h00, 1'b0, 1'b0},
         '{OP_SEND,  REG_DEST_MAC,   64'd0,    8'h00, 1'b0, 1'b0},
         '{OP_SEND,  REG_DEST_MAC,   64'd0,    8'h00, 1'b0, 1'b1},
         '{OP_SEND,  REG_DEST_MAC,   64'd0,    8'h00, 1'b1, 1'b0},  // fill of three
         '{OP_WRITE, REG_MIN_IDLE,   64'd63,   8'h00, 1'b0, 1'b0},  // clipped to 32
         '{OP_SEND,  REG_DEST_MAC,   64'd0,    8'h12, 1'b1, 1'b0},
         '{OP_WRITE, REG_DEST_MAC,   64'd0,    8'h00, 1'b0, 1'b0},
         '{OP_WRITE, REG_SRC_MAC,    64'd0,    8'h00, 1'b0, 1'b0},
         '{OP_WRITE, REG_ETHER_TYPE, 64'd0,    8'h00, 1'b0, 1'b0},
         '{OP_WRITE, REG_MIN_IDLE,   64'd33,   8'h00, 1'b0, 1'b0},  // just above range
         '{OP_SEND,  REG_DEST_MAC,   64'd0,    8'h7F, 1'b0, 1'b0},
         '{OP_SEND,  REG_DEST_MAC,   64'd0,    8'h3C, 1'b0, 1'b1},
         '{OP_SEND,  REG_DEST_MAC,   64'd0,    8'h01, 1'b1, 1'b0}   // fill of three
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < PLAN_ROWS; row++) begin
         if (directed_plan[row].op == OP_WRITE) begin
            drain();
            csr_write(directed_plan[row].reg_index, directed_plan[row].value);
         end else begin
            send_request(directed_plan[row].data, directed_plan[row].is_last,
                         directed_plan[row].typed);
         end
      end

      // random frames in three idling phases, fresh register settings each
      for (phase = 0; phase < 3; phase++) begin
         drain();
         csr_write(REG_DEST_MAC, pick_value());
         csr_write(REG_SRC_MAC, pick_value());
         csr_write(REG_ETHER_TYPE, pick_value());
         csr_write(REG_MIN_IDLE, pick_value());
         case (phase)
            0: begin
               send_idle_pct = 22;
               recv_idle_pct = 61;
            end
            1: begin
               send_idle_pct = 61;
               recv_idle_pct = 22;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            // mostly short frames, now and then a long one
            frame_len = ($urandom_range(9) == 0) ? $urandom_range(48, 13)
                                                 : $urandom_range(12, 1);
            for (k = 0; k < frame_len; k++) begin
               send_request(8'($urandom_range(255)), k == frame_len - 1, 1'b0);
               phase_items++;
            end
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d requests in %0d frames, %0d bytes checked, %0d register writes",
               requests_accepted, frames_accepted, bytes_checked, reg_writes);
      $display("Settings spanned all-zero and all-one headers and idle counts 0 to 63");
      if (mismatches == 0 && frame_bytes_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d bytes still expected", mismatches,
                  frame_bytes_due.size());
         $display("Verification failed");
      end
      $finish;
   end

endmodule
